FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the quaternion rotator.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: src/qrot_pkg.sv
// Package of the quaternion rotator: widths, CORDIC table, sequencer states.
// Used by all modules of the block; depends on nothing.
`default_nettype none
package qrot_pkg;
    localparam int FracBits   = 14;
    localparam int AngleBits  = 16;
    localparam int CordicIters = 20;
    localparam int CordicFrac = 30;
    localparam int IterW      = 5;
    localparam int StepW      = 5;
    localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
    localparam logic signed [33:0] QuarterTurn   = 34'sd1073741824;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_AXIS, S_HAM, S_MAT, S_DONE
    } t_state;

    typedef struct packed {
        logic start_cordic;
        logic load;
        logic step_axis;
        logic step_ham;
        logic step_mat;
        logic [StepW-1:0] step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
    } t_status;

    function automatic logic signed [33:0] atan_turn(input logic [IterW-1:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Round half up by FracBits and saturate to 16 bits.
    function automatic logic signed [15:0] q_round(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> FracBits;
        if (t > 36'sd32767) return 16'sh7fff;
        if (t < -36'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction
endpackage
`default_nettype wire

FILE: src/qrot_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on nothing.
`default_nettype none
interface qrot_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic signed [15:0] axis_x, axis_y, axis_z;
    logic [15:0] angle;
    logic signed [15:0] load_w, load_x, load_y, load_z;
    modport source(output valid, mode, axis_x, axis_y, axis_z, angle,
                   load_w, load_x, load_y, load_z, input ready);
    modport sink(input valid, mode, axis_x, axis_y, axis_z, angle,
                 load_w, load_x, load_y, load_z, output ready);
endinterface

interface qrot_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [17:0] norm_sq;
    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   norm_sq, input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 norm_sq, output ready);
endinterface
`default_nettype wire

FILE: src/qrot_ctrl.sv
// Sequencer of the quaternion rotator: issues datapath steps per item.
// Depends on qrot_pkg.
`default_nettype none
`include "assert_macros.svh"
module qrot_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_mode,
    output logic                 o_in_ready,
    input  wire                  i_out_busy,
    input  qrot_pkg::t_status    i_status,
    output qrot_pkg::t_cmd       o_cmd
);
    qrot_pkg::t_state r_state, n_state;
    logic [qrot_pkg::StepW-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qrot_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_in_ready = 1'b0;
        case (r_state)
            qrot_pkg::S_IDLE: begin
                o_in_ready = !i_out_busy;
                n_step = '0;
                if (i_in_valid && !i_out_busy) begin
                    if (i_mode) begin
                        o_cmd.load = 1'b1;
                        n_state = qrot_pkg::S_MAT;
                    end else begin
                        o_cmd.start_cordic = 1'b1;
                        n_state = qrot_pkg::S_CORDIC;
                    end
                end
            end
            qrot_pkg::S_CORDIC: begin
                if (i_status.cordic_done) begin
                    n_state = qrot_pkg::S_AXIS;
                end
            end
            qrot_pkg::S_AXIS: begin
                // one axis product per cycle
                o_cmd.step_axis = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 5'd2) begin
                    n_step = '0;
                    n_state = qrot_pkg::S_HAM;
                end
            end
            qrot_pkg::S_HAM: begin
                // sixteen products, the last one commits the quaternion
                o_cmd.step_ham = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 5'd16) begin
                    n_step = '0;
                    n_state = qrot_pkg::S_MAT;
                end
            end
            qrot_pkg::S_MAT: begin
                o_cmd.step_mat = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 5'd10) begin
                    n_step = '0;
                    n_state = qrot_pkg::S_DONE;
                end
            end
            qrot_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = qrot_pkg::S_IDLE;
            end
            default: n_state = qrot_pkg::S_IDLE;
        endcase
    end

    `CHK_IMPLY(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == qrot_pkg::S_IDLE)
    `CHK_NEXT(a_done_idle, i_clk, i_rst_n, r_state == qrot_pkg::S_DONE, r_state == qrot_pkg::S_IDLE)
    `CHK_IMPLY(a_step_rng, i_clk, i_rst_n, r_state == qrot_pkg::S_HAM, r_step <= 5'd16)
endmodule
`default_nettype wire

FILE: src/qrot_dp.sv
// Datapath: CORDIC sin/cos, one shared 16x16 multiplier, quaternion and matrix.
// Depends on qrot_pkg.
`default_nettype none
`include "assert_macros.svh"
module qrot_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  qrot_pkg::t_cmd        i_cmd,
    input  wire signed [15:0]     i_axis_x,
    input  wire signed [15:0]     i_axis_y,
    input  wire signed [15:0]     i_axis_z,
    input  wire [15:0]            i_angle,
    input  wire signed [15:0]     i_load_w,
    input  wire signed [15:0]     i_load_x,
    input  wire signed [15:0]     i_load_y,
    input  wire signed [15:0]     i_load_z,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic signed [15:0]    o_m [9],
    output logic [17:0]           o_norm_sq,
    output qrot_pkg::t_status     o_status
);
    // orientation and item registers
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [15:0] r_rw, r_rx, r_ry, r_rz;
    // CORDIC
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [qrot_pkg::IterW-1:0] r_it;
    logic r_cbusy, r_fold;
    // shared multiplier
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] r_prod;
    logic r_pv;
    logic [3:0] r_pidx;
    logic signed [35:0] r_acc;
    logic signed [15:0] r_nq [4];
    logic signed [35:0] r_macc [9];
    logic signed [35:0] r_nacc;
    logic r_out_valid;
    logic signed [15:0] r_m [9];
    logic [17:0] r_norm;

    // CORDIC step
    logic signed [33:0] cx_sh, cy_sh;
    logic signed [15:0] cos_r, sin_r, cos_v, sin_v;
    logic signed [33:0] z0;
    assign cx_sh = r_cx >>> r_it;
    assign cy_sh = r_cy >>> r_it;
    assign z0 = {2'b00, 1'b0, i_angle, 15'd0};

    function automatic logic signed [15:0] cround(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> (qrot_pkg::CordicFrac - qrot_pkg::FracBits);
        if (t > 34'sd32767) return 16'sh7fff;
        if (t < -34'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction

    assign cos_r = cround(r_cx);
    assign sin_r = cround(r_cy);
    always_comb begin
        if (r_fold) begin
            cos_v = (sin_r == 16'sh8000) ? 16'sh7fff : -sin_r;
            sin_v = cos_r;
        end else begin
            cos_v = cos_r;
            sin_v = sin_r;
        end
    end
    assign o_status.cordic_done = r_cbusy && (r_it == 5'(qrot_pkg::CordicIters));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_it <= '0;
        end else if (i_cmd.start_cordic) begin
            r_cbusy <= 1'b1;
            r_it <= '0;
        end else if (o_status.cordic_done) begin
            r_cbusy <= 1'b0;
        end else if (r_cbusy) begin
            r_it <= r_it + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_cordic) begin
            r_cx <= qrot_pkg::CordicGainInv;
            r_cy <= '0;
            if (z0 >= qrot_pkg::QuarterTurn) begin
                r_cz <= z0 - qrot_pkg::QuarterTurn;
                r_fold <= 1'b1;
            end else begin
                r_cz <= z0;
                r_fold <= 1'b0;
            end
            r_ax <= i_axis_x;
            r_ay <= i_axis_y;
            r_az <= i_axis_z;
        end else if (r_cbusy && !o_status.cordic_done) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - qrot_pkg::atan_turn(r_it);
            end else begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + qrot_pkg::atan_turn(r_it);
            end
        end
    end

    // Operand select: axis products, Hamilton terms, matrix/norm squares.
    // Hamilton: term t of component c uses r[rsel] * q[qsel] with sign.
    logic [3:0] s;
    logic ham_neg;
    logic [1:0] rsel, qsel;
    logic signed [15:0] rv, qv, qa, qb;
    always_comb begin
        s = i_cmd.step[3:0];
        rsel = s[1:0];
        ham_neg = 1'b0;
        qsel = 2'd0;
        case (s)
            4'd0:  begin qsel = 2'd0; end
            4'd1:  begin qsel = 2'd1; ham_neg = 1'b1; end
            4'd2:  begin qsel = 2'd2; ham_neg = 1'b1; end
            4'd3:  begin qsel = 2'd3; ham_neg = 1'b1; end
            4'd4:  begin qsel = 2'd1; end
            4'd5:  begin qsel = 2'd0; end
            4'd6:  begin qsel = 2'd3; end
            4'd7:  begin qsel = 2'd2; ham_neg = 1'b1; end
            4'd8:  begin qsel = 2'd2; end
            4'd9:  begin qsel = 2'd3; ham_neg = 1'b1; end
            4'd10: begin qsel = 2'd0; end
            4'd11: begin qsel = 2'd1; end
            4'd12: begin qsel = 2'd3; end
            4'd13: begin qsel = 2'd2; end
            4'd14: begin qsel = 2'd1; ham_neg = 1'b1; end
            4'd15: begin qsel = 2'd0; end
            default: qsel = 2'd0;
        endcase
        case (rsel)
            2'd0: rv = r_rw;
            2'd1: rv = r_rx;
            2'd2: rv = r_ry;
            default: rv = r_rz;
        endcase
        case (qsel)
            2'd0: qv = r_qw;
            2'd1: qv = r_qx;
            2'd2: qv = r_qy;
            default: qv = r_qz;
        endcase
        // matrix steps: ww xx yy zz xy xz yz wx wy wz
        case (s)
            4'd0: begin qa = r_qw; qb = r_qw; end
            4'd1: begin qa = r_qx; qb = r_qx; end
            4'd2: begin qa = r_qy; qb = r_qy; end
            4'd3: begin qa = r_qz; qb = r_qz; end
            4'd4: begin qa = r_qx; qb = r_qy; end
            4'd5: begin qa = r_qx; qb = r_qz; end
            4'd6: begin qa = r_qy; qb = r_qz; end
            4'd7: begin qa = r_qw; qb = r_qx; end
            4'd8: begin qa = r_qw; qb = r_qy; end
            default: begin qa = r_qw; qb = r_qz; end
        endcase
        mul_a = qa;
        mul_b = qb;
        if (i_cmd.step_axis) begin
            mul_a = sin_v;
            case (s[1:0])
                2'd0: mul_b = r_ax;
                2'd1: mul_b = r_ay;
                default: mul_b = r_az;
            endcase
        end else if (i_cmd.step_ham) begin
            mul_a = rv;
            mul_b = qv;
        end
    end

    logic r_ham_neg;
    logic r_pham, r_pmat;
    logic signed [35:0] pext, acc_n;
    assign pext = 36'(r_prod);
    assign acc_n = r_ham_neg ? r_acc - pext : r_acc + pext;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pidx <= s;
        r_ham_neg <= ham_neg;
        r_pham <= i_cmd.step_ham && (i_cmd.step != 5'd16);
        r_pmat <= i_cmd.step_mat && (i_cmd.step != 5'd10);
        r_pv <= i_cmd.step_axis;
        if (i_cmd.step_axis && s[1:0] == 2'd0) begin
            r_rw <= cos_v;
        end
        if (r_pv) begin
            case (r_pidx[1:0])
                2'd0: r_rx <= qrot_pkg::q_round(36'(r_prod));
                2'd1: r_ry <= qrot_pkg::q_round(36'(r_prod));
                default: r_rz <= qrot_pkg::q_round(36'(r_prod));
            endcase
        end
        if (r_pham) begin
            if (r_pidx[1:0] == 2'd3) begin
                r_nq[r_pidx[3:2]] <= qrot_pkg::q_round(acc_n);
                r_acc <= '0;
            end else begin
                r_acc <= acc_n;
            end
        end else if (!i_cmd.step_ham) begin
            r_acc <= '0;
        end
        if (r_pmat) begin
            case (r_pidx)
                4'd0: r_nacc <= pext;
                4'd1: r_nacc <= r_nacc + pext;
                4'd2: r_nacc <= r_nacc + pext;
                4'd3: r_nacc <= r_nacc + pext;
                default: r_nacc <= r_nacc;
            endcase
            case (r_pidx)
                4'd1: r_macc[0] <= pext;
                4'd2: r_macc[2] <= pext;
                4'd3: r_macc[3] <= pext;
                4'd4: r_macc[4] <= pext;
                4'd5: r_macc[5] <= pext;
                4'd6: r_macc[6] <= pext;
                4'd7: r_macc[7] <= pext;
                4'd8: r_macc[8] <= pext;
                default: r_macc[1] <= pext;
            endcase
        end
        if (!i_rst_n) begin
            r_qw <= 16'sd16384; r_qx <= '0; r_qy <= '0; r_qz <= '0;
        end else if (i_cmd.load) begin
            r_qw <= i_load_w; r_qx <= i_load_x; r_qy <= i_load_y; r_qz <= i_load_z;
        end else if (i_cmd.step_ham && i_cmd.step == 5'd16) begin
            r_qw <= r_nq[0]; r_qx <= r_nq[1]; r_qy <= r_nq[2];
            r_qz <= qrot_pkg::q_round(acc_n);
        end
    end

    // matrix from squares: macc0=xx 2=yy 3=zz 4=xy 5=xz 6=yz 7=wx 8=wy 1=wz
    logic signed [35:0] one2;
    logic signed [35:0] xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;
    assign one2 = 36'sd1 <<< (2 * qrot_pkg::FracBits);
    assign xx2 = r_macc[0] <<< 1;
    assign yy2 = r_macc[2] <<< 1;
    assign zz2 = r_macc[3] <<< 1;
    assign xy2 = r_macc[4] <<< 1;
    assign xz2 = r_macc[5] <<< 1;
    assign yz2 = r_macc[6] <<< 1;
    assign wx2 = r_macc[7] <<< 1;
    assign wy2 = r_macc[8] <<< 1;
    assign wz2 = r_macc[1] <<< 1;
    logic signed [35:0] nr;
    assign nr = (r_nacc + 36'sd8192) >>> qrot_pkg::FracBits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_m[0] <= qrot_pkg::q_round(one2 - yy2 - zz2);
            r_m[1] <= qrot_pkg::q_round(xy2 - wz2);
            r_m[2] <= qrot_pkg::q_round(xz2 + wy2);
            r_m[3] <= qrot_pkg::q_round(xy2 + wz2);
            r_m[4] <= qrot_pkg::q_round(one2 - xx2 - zz2);
            r_m[5] <= qrot_pkg::q_round(yz2 - wx2);
            r_m[6] <= qrot_pkg::q_round(xz2 - wy2);
            r_m[7] <= qrot_pkg::q_round(yz2 + wx2);
            r_m[8] <= qrot_pkg::q_round(one2 - xx2 - yy2);
            if (nr > 36'sd262143) r_norm <= 18'h3ffff;
            else if (nr < 0) r_norm <= '0;
            else r_norm <= nr[17:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_m = r_m;
    assign o_norm_sq = r_norm;

    `CHK_IMPLY(a_cordic_it, i_clk, i_rst_n, r_cbusy, r_it <= 5'(qrot_pkg::CordicIters))
    `CHK_NEXT(a_fin_valid, i_clk, i_rst_n, i_cmd.finish, r_out_valid)
    `CHK_IMPLY(a_no_overlap, i_clk, i_rst_n, i_cmd.step_ham, !r_cbusy)
endmodule
`default_nettype wire

FILE: src/quaternion_orientation_rotator_unit.sv
// Quaternion orientation rotator: keeps an orientation quaternion and gives
// the rotation matrix and squared norm after each item. Uses qrot_pkg,
// the channel interfaces, qrot_ctrl and qrot_dp.
//
// Input channel: one item per handshake; mode 0 rotates the stored
// quaternion by axis and half-angle sin/cos, mode 1 loads it directly.
// Output channel: one result item per input item, from an output register.
// A rotate item runs 20 CORDIC iterations, then 3 axis, 17 Hamilton and 11
// matrix steps on one shared 16x16 multiplier, and then its result is latched
// into the output register; a load item runs only the 11 matrix steps before
// its result is latched.
// One item is worked on at a time: the next item is taken only once the
// sequencer has returned to idle after the last item.
// A new item is taken only while the output register is empty or drains in
// the same cycle; while the receiver stalls, the finished result holds and
// the next item waits at the input.
// Reset: the quaternion returns to identity (w = 1.0), the output is empty.
`default_nettype none
module quaternion_orientation_rotator_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    qrot_in_if.sink    in_ch,
    qrot_out_if.source out_ch
);
    qrot_pkg::t_cmd    cmd;
    qrot_pkg::t_status status;
    logic signed [15:0] m [9];

    qrot_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_mode(in_ch.mode),
        .o_in_ready(in_ch.ready),
        .i_out_busy(out_ch.valid && !out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    qrot_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_axis_x(in_ch.axis_x), .i_axis_y(in_ch.axis_y), .i_axis_z(in_ch.axis_z),
        .i_angle(in_ch.angle),
        .i_load_w(in_ch.load_w), .i_load_x(in_ch.load_x),
        .i_load_y(in_ch.load_y), .i_load_z(in_ch.load_z),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_m(m), .o_norm_sq(out_ch.norm_sq), .o_status(status)
    );

    assign out_ch.m00 = m[0];
    assign out_ch.m01 = m[1];
    assign out_ch.m02 = m[2];
    assign out_ch.m10 = m[3];
    assign out_ch.m11 = m[4];
    assign out_ch.m12 = m[5];
    assign out_ch.m20 = m[6];
    assign out_ch.m21 = m[7];
    assign out_ch.m22 = m[8];
endmodule
`default_nettype wire
